// ===== rtl/core/eai_pkg.sv =====
// ----------------------------------------------------------------------------
// eai_pkg: shared types and constants of the edge attribute interpolator
// Holds the item and result payload structs and the action codes.
// ----------------------------------------------------------------------------
package eai_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_START = 2'd0,
        ACT_LOAD_END   = 2'd1,
        ACT_QUERY      = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [31:0] depth_in;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic signed [15:0] normal_x_in;
        logic signed [15:0] normal_y_in;
        logic signed [15:0] normal_z_in;
    } item_t;

    typedef struct packed {
        logic signed [31:0] depth_out;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic signed [15:0] unit_normal_x;
        logic signed [15:0] unit_normal_y;
        logic signed [15:0] unit_normal_z;
        logic signed [15:0] edge_y_low;
        logic signed [15:0] edge_y_high;
        logic               point_edge;
    } result_t;

    // One vertex as stored in the edge registers.
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [31:0] depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } vertex_t;

    // Query job handed from the front to the back.
    typedef struct packed {
        vertex_t            sv;
        vertex_t            ev;
        logic signed [23:0] q;
        logic               vert;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_NEXT,
        ST_NSHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_NDIV,
        ST_DONE
    } back_state_t;

endpackage

// ===== rtl/core/eai_front.sv =====
// ----------------------------------------------------------------------------
// eai_front: vertex registers and query issue
// Store vertex loads, turn a query into a job for the back end.
// ----------------------------------------------------------------------------
module eai_front (
    input  logic            clk,
    input  logic            rst_n,
    input  eai_pkg::item_t  item,
    input  logic            item_valid,
    output eai_pkg::job_t   job,
    output logic            job_valid
);
    import eai_pkg::*;

    vertex_t start_reg, end_reg;
    vertex_t load_v;

    always_comb
    begin
        load_v.x     = item.pos_x;
        load_v.y     = item.pos_y;
        load_v.depth = item.depth_in;
        load_v.red   = item.red_in;
        load_v.green = item.green_in;
        load_v.blue  = item.blue_in;
        load_v.nx    = item.normal_x_in;
        load_v.ny    = item.normal_y_in;
        load_v.nz    = item.normal_z_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
        end
        else if (item_valid && item.action == ACT_LOAD_START)
            start_reg <= load_v;
        else if (item_valid && item.action == ACT_LOAD_END)
            end_reg <= load_v;
    end

    // Loads are taken in order with queries, so the job snapshots the
    // vertices as they stand now.
    always_comb
    begin
        job.sv   = start_reg;
        job.ev   = end_reg;
        job.vert = (start_reg.x == end_reg.x);
        job.q    = job.vert ? item.pos_y : item.pos_x;
    end
    assign job_valid = item_valid && (item.action == ACT_QUERY);

endmodule

// ===== rtl/core/eai_queue.sv =====
// ----------------------------------------------------------------------------
// eai_queue: two-entry job queue
// Decouple the front end from the back end.
// ----------------------------------------------------------------------------
module eai_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  eai_pkg::job_t  wr_data,
    input  logic           wr_en,
    output logic           full,
    output eai_pkg::job_t  rd_data,
    output logic           rd_valid,
    input  logic           rd_en
);
    import eai_pkg::*;

    job_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

// ===== rtl/core/eai_back.sv =====
// ----------------------------------------------------------------------------
// eai_back: interpolation and normalization sequencer
// Run seven lerps on one shared serial divider, then a
// bit-serial square root and three more divides for the unit normal.
// ----------------------------------------------------------------------------
module eai_back #(
    parameter int POS_FRAC_BITS    = 8,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eai_pkg::job_t     job,
    input  logic              job_valid,
    output logic              job_take,
    output eai_pkg::result_t  res,
    output logic              res_valid,
    input  logic              res_take
);
    import eai_pkg::*;

    localparam int DW = 68;  // numerator magnitude width
    localparam int VW = 60;  // interpolated value width, covers depth extrapolation

    localparam logic signed [VW-1:0] DEPTH_MAX = VW'(64'sd2147483647);
    localparam logic signed [VW-1:0] DEPTH_MIN = VW'(-64'sd2147483648);
    localparam logic signed [VW-1:0] COLOR_MAX = VW'(64'sd255);

    back_state_t st_reg, st_next;
    job_t        job_reg;
    logic [2:0]  idx_reg;
    logic [6:0]  cnt_reg;
    logic signed [32:0] sv_c, ev_c;
    logic signed [24:0] d_reg, off_reg;
    logic signed [33:0] diff_reg;
    logic signed [66:0] num_reg;
    logic        nneg_reg;
    logic [DW-1:0] rem_reg, quo_reg, dvd_reg;
    logic [24:0]   dvs_reg;
    logic signed [VW-1:0] v_reg [7];
    logic        point_reg;
    logic [49:0] mag_reg [3];
    logic [63:0] sum_reg, sqv_reg, sqr_reg;
    logic [31:0] len_reg;
    logic [15:0] un_reg [3];
    logic        dout_reg;
    result_t     res_reg;

    // Attribute select for the current lerp.
    always_comb
    begin
        case (idx_reg)
            3'd0: begin sv_c = 33'(job_reg.sv.depth); ev_c = 33'(job_reg.ev.depth); end
            3'd1: begin sv_c = 33'({1'b0, job_reg.sv.red}); ev_c = 33'({1'b0, job_reg.ev.red}); end
            3'd2: begin sv_c = 33'({1'b0, job_reg.sv.green});
                        ev_c = 33'({1'b0, job_reg.ev.green}); end
            3'd3: begin sv_c = 33'({1'b0, job_reg.sv.blue}); ev_c = 33'({1'b0, job_reg.ev.blue}); end
            3'd4: begin sv_c = 33'(job_reg.sv.nx); ev_c = 33'(job_reg.ev.nx); end
            3'd5: begin sv_c = 33'(job_reg.sv.ny); ev_c = 33'(job_reg.ev.ny); end
            3'd6: begin sv_c = 33'(job_reg.sv.nz); ev_c = 33'(job_reg.ev.nz); end
            default: begin sv_c = '0; ev_c = '0; end
        endcase
    end

    logic [DW:0] trial;
    logic [49:0] maxm;
    logic [63:0] sq_try;
    logic [66:0] nmag;
    logic signed [VW:0] qsign;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DW-1]} - {{(DW-24){1'b0}}, dvs_reg};
        maxm = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        if (mag_reg[2] > maxm)
            maxm = mag_reg[2];
        sq_try = sqr_reg | sqv_reg;
        nmag = num_reg[66] ? 67'(-num_reg) : num_reg;
        qsign = nneg_reg ? -$signed({1'b0, quo_reg[VW-1:0]}) : $signed({1'b0, quo_reg[VW-1:0]});
    end

    function automatic logic [15:0] ytrunc(input logic signed [23:0] y);
        logic signed [23:0] t;
        begin
            t = y >>> POS_FRAC_BITS;
            if (y[23] && (y & 24'((1 << POS_FRAC_BITS) - 1)) != '0)
                t = t + 24'sd1;
            if (t > 24'sd32767)
                ytrunc = 16'h7fff;
            else if (t < -24'sd32768)
                ytrunc = 16'h8000;
            else
                ytrunc = t[15:0];
        end
    endfunction

    // Datapath for every state; the serial divides give one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                if (job_valid)
                    job_reg <= job;
                idx_reg <= '0;
            end
            ST_SETUP:
            begin
                point_reg <= (job_reg.sv.x == job_reg.ev.x) && (job_reg.sv.y == job_reg.ev.y);
                if (job_reg.vert)
                begin
                    d_reg   <= 25'(job_reg.ev.y) - 25'(job_reg.sv.y);
                    off_reg <= 25'(job_reg.q) - 25'(job_reg.sv.y);
                end
                else
                begin
                    d_reg   <= 25'(job_reg.ev.x) - 25'(job_reg.sv.x);
                    off_reg <= 25'(job_reg.q) - 25'(job_reg.sv.x);
                end
            end
            ST_MUL:
            begin
                diff_reg <= 34'(ev_c) - 34'(sv_c);
                num_reg  <= 67'(sv_c) * 67'(d_reg);
                cnt_reg  <= 7'd1;
            end
            ST_DIV:
            begin
                if (cnt_reg == 7'd1)
                begin
                    // second product term, then sign fold
                    num_reg <= num_reg + 67'(off_reg) * 67'(diff_reg);
                    cnt_reg <= 7'd2;
                end
                else if (cnt_reg == 7'd2)
                begin
                    nneg_reg <= num_reg[66] ^ d_reg[24];
                    dvd_reg  <= DW'(nmag);
                    dvs_reg  <= d_reg[24] ? 25'(-d_reg) : d_reg;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= 7'd3;
                end
                else
                begin
                    if (!trial[DW])
                        rem_reg <= trial[DW-1:0];
                    else
                        rem_reg <= {rem_reg[DW-2:0], dvd_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], ~trial[DW]};
                    dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
            ST_NEXT:
            begin
                if (point_reg)
                    v_reg[idx_reg] <= VW'((sv_c < ev_c) ? sv_c : ev_c);
                else
                    v_reg[idx_reg] <= qsign[VW-1:0];
                idx_reg <= idx_reg + 3'd1;
                // arm the magnitude load of the normal stage
                cnt_reg <= 7'd0;
            end
            ST_NSHIFT:
            begin
                if (cnt_reg == 7'd0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= v_reg[4+i][VW-1] ? 50'(-v_reg[4+i]) : 50'(v_reg[4+i]);
                    cnt_reg <= 7'd1;
                end
                else if (maxm[49:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                end
                else
                begin
                    sum_reg <= '0;
                    idx_reg <= '0;
                end
            end
            ST_SQUARE:
            begin
                sum_reg <= sum_reg + 64'(mag_reg[idx_reg[1:0]][30:0])
                                     * 64'(mag_reg[idx_reg[1:0]][30:0]);
                idx_reg <= idx_reg + 3'd1;
                sqv_reg <= 64'h4000_0000_0000_0000;
                sqr_reg <= '0;
                cnt_reg <= '0;
            end
            ST_SQRT:
            begin
                if (sum_reg >= sq_try)
                begin
                    sum_reg <= sum_reg - sq_try;
                    sqr_reg <= (sqr_reg >> 1) | sqv_reg;
                end
                else
                    sqr_reg <= sqr_reg >> 1;
                sqv_reg <= sqv_reg >> 2;
                idx_reg <= '0;
                cnt_reg <= 7'd2;
                len_reg <= 32'((sum_reg >= sq_try) ? ((sqr_reg >> 1) | sqv_reg) : (sqr_reg >> 1));
            end
            ST_NDIV:
            begin
                if (cnt_reg == 7'd2)
                begin
                    dvd_reg <= DW'({mag_reg[idx_reg[1:0]][30:0], NORMAL_FRAC_BITS'(0)});
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= 7'd3;
                end
                else if (cnt_reg != 7'(DW + 3))
                begin
                    if ({rem_reg, dvd_reg[DW-1]} >= {1'b0, 36'd0, len_reg})
                    begin
                        rem_reg <= DW'({rem_reg, dvd_reg[DW-1]} - {37'd0, len_reg});
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DW-2:0], dvd_reg[DW-1]};
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 7'd1;
                end
                else
                begin
                    if (len_reg == '0)
                        un_reg[idx_reg[1:0]] <= '0;
                    else if (v_reg[4+idx_reg][VW-1])
                        un_reg[idx_reg[1:0]] <= (quo_reg > 68'd32768) ? 16'h8000
                                                : 16'(-quo_reg[16:0]);
                    else
                        un_reg[idx_reg[1:0]] <= (quo_reg > 68'd32767) ? 16'h7fff
                                                : quo_reg[15:0];
                    idx_reg <= idx_reg + 3'd1;
                    cnt_reg <= 7'd2;
                end
            end
            default: ;
        endcase
        if (st_reg == ST_DONE && !dout_reg)
        begin
            res_reg.depth_out <= (v_reg[0] > DEPTH_MAX) ? 32'h7fffffff :
                                 (v_reg[0] < DEPTH_MIN) ? 32'h80000000 : v_reg[0][31:0];
            res_reg.red_out   <= v_reg[1][VW-1] ? 8'd0 : (v_reg[1] > COLOR_MAX) ? 8'hff
                                 : v_reg[1][7:0];
            res_reg.green_out <= v_reg[2][VW-1] ? 8'd0 : (v_reg[2] > COLOR_MAX) ? 8'hff
                                 : v_reg[2][7:0];
            res_reg.blue_out  <= v_reg[3][VW-1] ? 8'd0 : (v_reg[3] > COLOR_MAX) ? 8'hff
                                 : v_reg[3][7:0];
            res_reg.unit_normal_x <= un_reg[0];
            res_reg.unit_normal_y <= un_reg[1];
            res_reg.unit_normal_z <= un_reg[2];
            res_reg.edge_y_low  <= ytrunc((job_reg.sv.y < job_reg.ev.y) ? job_reg.sv.y : job_reg.ev.y);
            res_reg.edge_y_high <= ytrunc((job_reg.sv.y > job_reg.ev.y) ? job_reg.sv.y : job_reg.ev.y);
            res_reg.point_edge  <= point_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            dout_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_DONE && !dout_reg)
                dout_reg <= 1'b1;
            else if (dout_reg && res_take)
                dout_reg <= 1'b0;
        end
    end

    always_comb
    begin
        st_next  = st_reg;
        job_take = 1'b0;
        case (st_reg)
            ST_IDLE:   if (job_valid) begin st_next = ST_SETUP; job_take = 1'b1; end
            ST_SETUP:  st_next = ST_MUL;
            ST_MUL:    st_next = point_reg ? ST_NEXT : ST_DIV;
            ST_DIV:    if (cnt_reg == 7'(DW + 2)) st_next = ST_NEXT;
            ST_NEXT:   st_next = (idx_reg == 3'd6) ? ST_NSHIFT : ST_MUL;
            ST_NSHIFT: if (cnt_reg != 7'd0 && maxm[49:31] == '0) st_next = ST_SQUARE;
            ST_SQUARE: if (idx_reg == 3'd2) st_next = ST_SQRT;
            ST_SQRT:   if (sqv_reg == 64'd1) st_next = ST_NDIV;
            ST_NDIV:   if (cnt_reg == 7'(DW + 3) && idx_reg == 3'd2) st_next = ST_DONE;
            ST_DONE:   if (!dout_reg) st_next = ST_DONE; else if (res_take) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    assign res       = res_reg;
    assign res_valid = dout_reg;

endmodule

// ===== rtl/core/edge_attribute_interpolator.sv =====
// ----------------------------------------------------------------------------
// edge_attribute_interpolator: linear attribute interpolation along one edge
// Queue-style top level joining the front end, job queue and back end.
// ----------------------------------------------------------------------------
// Load beats (action 0/1) are absorbed and give no result.
// A query beat becomes a job in a two-entry queue; the back end works one
// job at a time: seven lerps on a shared serial divider (one quotient bit
// per cycle), a 32-step bit-serial square root and three normalization
// divides, after the normal is scaled down when its largest magnitude is
// wider than 31 bits; a point edge skips the lerp divides. The serial
// divider sets the rate. The result register holds one finished result
// until popped.
module edge_attribute_interpolator #(
    parameter int POS_FRAC_BITS    = 8,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eai_pkg::item_t    item,
    input  logic              push,
    output logic              full,
    output eai_pkg::result_t  result,
    output logic              empty,
    input  logic              pop
);
    import eai_pkg::*;

    job_t fj, bj;
    logic fj_valid, bj_valid, bj_take, res_valid, acc;

    // Hold every beat while the queue is full; a query snapshots the
    // vertices at acceptance, so later loads never reach a waiting job.
    assign acc = push && !full;

    eai_front u_front (
        .clk(clk), .rst_n(rst_n), .item(item), .item_valid(acc),
        .job(fj), .job_valid(fj_valid)
    );

    eai_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(fj), .wr_en(fj_valid), .full(full),
        .rd_data(bj), .rd_valid(bj_valid), .rd_en(bj_take)
    );

    eai_back #(
        .POS_FRAC_BITS(POS_FRAC_BITS),
        .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .job(bj), .job_valid(bj_valid), .job_take(bj_take),
        .res(result), .res_valid(res_valid), .res_take(pop)
    );

    assign empty = !res_valid;

    // Drop of a result while it waits would lose a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

endmodule
